// ===== rtl/dtfp_pkg.sv =====
// ----------------------------------------------------------------------------
// dtfp_pkg
// Shared types, character codes and power-of-ten tables for the decimal text
// to fixed-point converter.
// ----------------------------------------------------------------------------
package dtfp_pkg;

    localparam logic [7:0]  CharZero  = 8'h30;
    localparam logic [7:0]  CharNine  = 8'h39;
    localparam logic [7:0]  CharPoint = 8'h2E;
    localparam logic [7:0]  CharMinus = 8'h2D;

    localparam logic [30:0] MagMax          = 31'h7FFF_FFFF;
    localparam logic [3:0]  FracDigitsReset = 4'd2;

    // finished string on its way to scaling
    typedef struct packed {
        logic [30:0] mag;
        logic [3:0]  pad_cnt;
        logic        negative;
        logic        saturated;
    } pad_req_t;

    // ten to the power k, zero where it does not fit (any nonzero magnitude saturates)
    function automatic logic [29:0] pow10(input logic [3:0] k);
        logic [29:0] p;
        begin
            case (k)
                4'd0:    p = 30'd1;
                4'd1:    p = 30'd10;
                4'd2:    p = 30'd100;
                4'd3:    p = 30'd1000;
                4'd4:    p = 30'd10000;
                4'd5:    p = 30'd100000;
                4'd6:    p = 30'd1000000;
                4'd7:    p = 30'd10000000;
                4'd8:    p = 30'd100000000;
                4'd9:    p = 30'd1000000000;
                default: p = 30'd0;
            endcase
            return p;
        end
    endfunction

    // largest magnitude that still fits after scaling by ten to the power k
    function automatic logic [30:0] pad_limit(input logic [3:0] k);
        logic [30:0] l;
        begin
            case (k)
                4'd0:    l = MagMax;
                4'd1:    l = 31'd214748364;
                4'd2:    l = 31'd21474836;
                4'd3:    l = 31'd2147483;
                4'd4:    l = 31'd214748;
                4'd5:    l = 31'd21474;
                4'd6:    l = 31'd2147;
                4'd7:    l = 31'd214;
                4'd8:    l = 31'd21;
                4'd9:    l = 31'd2;
                default: l = 31'd0;
            endcase
            return l;
        end
    endfunction

endpackage

// ===== rtl/dtfp_parse.sv =====
// ----------------------------------------------------------------------------
// dtfp_parse
// Input register and per-string parser state; hands each finished string to
// the scaling stage as one request.
// ----------------------------------------------------------------------------
module dtfp_parse (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [3:0]        fraction_digits,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        character,
    input  logic              last,
    output logic              pad_valid,
    input  logic              pad_ready,
    output dtfp_pkg::pad_req_t pad_req
);
    import dtfp_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  char_reg;
    logic        last_reg;

    logic [30:0] mag_reg, mag_next;
    logic [3:0]  frac_cnt_reg, frac_cnt_next;
    logic        negative_reg, negative_next;
    logic        point_seen_reg, point_seen_next;
    logic        stopped_reg, stopped_next;
    logic        first_char_reg, first_char_next;
    logic        saturated_reg, saturated_next;

    logic        consume;
    logic        in_ready;
    logic        is_digit;
    logic [34:0] mac_sum;

    assign consume  = in_valid_reg && (!last_reg || pad_ready);
    assign in_ready = !in_valid_reg || consume;
    assign in_stall = !in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            char_reg <= character;
            last_reg <= last;
        end
    end

    always_comb
    begin
        is_digit = char_reg inside {[CharZero:CharNine]};
        // magnitude * 10 + digit
        mac_sum  = ({4'b0, mag_reg} << 3) + ({4'b0, mag_reg} << 1) + {31'b0, char_reg[3:0]};

        mag_next        = mag_reg;
        frac_cnt_next   = frac_cnt_reg;
        negative_next   = negative_reg;
        point_seen_next = point_seen_reg;
        stopped_next    = stopped_reg;
        first_char_next = first_char_reg;
        saturated_next  = saturated_reg;

        if (consume)
        begin
            if (!stopped_reg)
            begin
                if (is_digit)
                begin
                    if (point_seen_reg && fraction_digits == 4'd0)
                    begin
                        stopped_next = 1'b1;
                    end
                    else
                    begin
                        if (mac_sum > {4'b0, MagMax})
                        begin
                            mag_next       = MagMax;
                            saturated_next = 1'b1;
                        end
                        else
                        begin
                            mag_next = mac_sum[30:0];
                        end
                        if (point_seen_reg)
                        begin
                            frac_cnt_next = frac_cnt_reg + 4'd1;
                            if (frac_cnt_next >= fraction_digits)
                            begin
                                stopped_next = 1'b1;
                            end
                        end
                    end
                end
                else if (char_reg == CharPoint)
                begin
                    if (point_seen_reg)
                    begin
                        stopped_next = 1'b1;
                    end
                    else
                    begin
                        point_seen_next = 1'b1;
                    end
                end
                else if (char_reg == CharMinus && first_char_reg)
                begin
                    negative_next = 1'b1;
                end
                else
                begin
                    stopped_next = 1'b1;
                end
            end
            first_char_next = 1'b0;
        end

        pad_valid         = consume && last_reg;
        pad_req.mag       = mag_next;
        pad_req.pad_cnt   = (frac_cnt_next < fraction_digits) ?
                            (fraction_digits - frac_cnt_next) : 4'd0;
        pad_req.negative  = negative_next;
        pad_req.saturated = saturated_next;

        // string done: start over
        if (consume && last_reg)
        begin
            mag_next        = '0;
            frac_cnt_next   = '0;
            negative_next   = 1'b0;
            point_seen_next = 1'b0;
            stopped_next    = 1'b0;
            first_char_next = 1'b1;
            saturated_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_reg        <= '0;
            frac_cnt_reg   <= '0;
            negative_reg   <= 1'b0;
            point_seen_reg <= 1'b0;
            stopped_reg    <= 1'b0;
            first_char_reg <= 1'b1;
            saturated_reg  <= 1'b0;
        end
        else
        begin
            mag_reg        <= mag_next;
            frac_cnt_reg   <= frac_cnt_next;
            negative_reg   <= negative_next;
            point_seen_reg <= point_seen_next;
            stopped_reg    <= stopped_next;
            first_char_reg <= first_char_next;
            saturated_reg  <= saturated_next;
        end
    end

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        pad_valid |=> first_char_reg && mag_reg == '0 && !stopped_reg && !saturated_reg)
        else $error("string state not cleared after last character");

    a_frac_needs_point: assert property (@(posedge clk) disable iff (!rst_n)
        frac_cnt_reg != 4'd0 |-> point_seen_reg)
        else $error("fraction digits counted without a point");

    a_sat_holds_max: assert property (@(posedge clk) disable iff (!rst_n)
        saturated_reg |-> mag_reg == MagMax || mag_reg != '0)
        else $error("saturated string lost its magnitude");

endmodule

// ===== rtl/dtfp_scale.sv =====
// ----------------------------------------------------------------------------
// dtfp_scale
// Pads missing fraction digits by a power of ten with saturation, applies the
// sign and holds the result until it is taken.
// ----------------------------------------------------------------------------
module dtfp_scale (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pad_valid,
    output logic               pad_ready,
    input  dtfp_pkg::pad_req_t pad_req,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        value,
    output logic               overflow
);
    import dtfp_pkg::*;

    logic        pad_valid_reg;
    pad_req_t    pad_reg;
    logic        out_valid_reg;
    logic [31:0] value_reg, value_next;
    logic        overflow_reg, overflow_next;

    logic        out_ready;
    logic [60:0] prod;
    logic [30:0] scaled;
    logic        over;

    assign out_ready = !out_valid_reg || !out_stall;
    assign pad_ready = !pad_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pad_ready)
            begin
                pad_valid_reg <= pad_valid;
            end
            if (out_ready)
            begin
                out_valid_reg <= pad_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pad_ready && pad_valid)
        begin
            pad_reg <= pad_req;
        end
        if (out_ready && pad_valid_reg)
        begin
            value_reg    <= value_next;
            overflow_reg <= overflow_next;
        end
    end

    always_comb
    begin
        // past the limit the product cannot fit in 31 bits, so its low bits are used only below it
        over          = pad_reg.mag > pad_limit(pad_reg.pad_cnt);
        prod          = 61'(pad_reg.mag) * 61'(pow10(pad_reg.pad_cnt));
        scaled        = over ? MagMax : prod[30:0];
        overflow_next = pad_reg.saturated || over;
        value_next    = pad_reg.negative ? (32'd0 - {1'b0, scaled}) : {1'b0, scaled};
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign overflow  = overflow_reg;

    a_no_min_int: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> value_reg != 32'h8000_0000)
        else $error("result outside symmetric range");

    a_ovf_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && overflow_reg |->
            value_reg == {1'b0, MagMax} || value_reg == (32'd0 - {1'b0, MagMax}))
        else $error("overflow flagged without saturated value");

    a_pad_held: assert property (@(posedge clk) disable iff (!rst_n)
        pad_valid_reg && !out_ready |=> pad_valid_reg && $stable(pad_reg))
        else $error("pending scale request dropped");

endmodule

// ===== rtl/decimal_text_to_fixed_point_top.sv =====
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point_top
// ASCII decimal text to signed fixed-point integer with configurable
// fraction digits and saturation.
// ----------------------------------------------------------------------------
// a finished string goes to the scale request register, then to the output register
// throughput: one character per cycle while in_stall is low, set by the parse update
// scaling by the pad power of ten is one registered 31x30 multiply
// reset clears all string state and sets fraction_digits to 2
// while out_stall is high, input stalls once a last character waits behind two results
module decimal_text_to_fixed_point_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [3:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  character,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] value,
    output logic        overflow
);
    import dtfp_pkg::*;

    logic [3:0] fraction_digits_reg;
    logic       pad_valid;
    logic       pad_ready;
    pad_req_t   pad_req;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fraction_digits_reg <= FracDigitsReset;
        end
        else if (cfg_write)
        begin
            fraction_digits_reg <= cfg_data;
        end
    end

    dtfp_parse u_parse (
        .clk             (clk),
        .rst_n           (rst_n),
        .fraction_digits (fraction_digits_reg),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .character       (character),
        .last            (last),
        .pad_valid       (pad_valid),
        .pad_ready       (pad_ready),
        .pad_req         (pad_req)
    );

    dtfp_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .pad_valid (pad_valid),
        .pad_ready (pad_ready),
        .pad_req   (pad_req),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .overflow  (overflow)
    );

endmodule
